// ===== design/tetra_isosurface_cut_assert.svh =====
`ifndef TETRA_ISOSURFACE_CUT_ASSERT_SVH
`define TETRA_ISOSURFACE_CUT_ASSERT_SVH

// Same-cycle implication on aclk, switched off while aresetn is low
`define TIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, switched off while aresetn is low
`define TIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tic_pkg.sv =====
`default_nettype none

package tic_pkg;

    // Field and datapath widths
    localparam int VAL_W  = 32;
    localparam int EPS_W  = 16;
    localparam int FRAC_W = 17;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // One lane per possible polygon corner
    localparam int LANES = 4;

    // One quotient bit per divider stage
    localparam int QBITS = FRAC_W;

    // Lane registers behind the case select: operand stage, divider steps, clamp
    localparam int LANE_DEPTH = QBITS + 2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [EPS_W-1:0]        eps_t;
    typedef logic [FRAC_W-1:0]       frac_t;
    typedef logic [1:0]              vidx_t;

    localparam frac_t FRAC_ONE  = frac_t'(1 << (FRAC_W - 1));
    localparam val_t  ISO_RESET = '0;
    localparam eps_t  EPS_RESET = eps_t'(1);

    // Final corner number of a quad and of a triangle
    localparam vidx_t LAST_QUAD = vidx_t'(LANES - 1);
    localparam vidx_t LAST_TRI  = vidx_t'(LANES - 2);

    // Register map, indexed by paddr[2]
    typedef enum logic {
        REG_ISO_LEVEL = 1'b0,
        REG_CLAMP_EPS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        vidx_t from_v;
        vidx_t to_v;
    } edge_t;

    // Item-level info that travels alongside the lanes
    typedef struct packed {
        logic                  cut;
        logic                  is_quad;
        edge_t [LANES-1:0]     edges;
    } item_meta_t;

    // Cut edges per crossing case, slot 0 in the low nibble, {from, to} per nibble.
    // Case index is {v1 differs, v2 differs, v3 differs} from vertex 0.
    localparam logic [15:0] CASE_EDGES [8] = '{
        16'h0000, 16'h0B73, 16'h06E2, 16'h6732,
        16'h0D91, 16'h3B91, 16'hDE21, 16'h0321
    };

    // Cases that give a quad
    localparam logic [7:0] QUAD_CASES = 8'b0110_1000;

    function automatic edge_t case_edge(input logic [2:0] idx, input vidx_t slot);
        logic [15:0] row;
        row = CASE_EDGES[idx];
        return edge_t'(row[{slot, 2'b00} +: 4]);
    endfunction

endpackage

`default_nettype wire

// ===== design/tic_select.sv =====
`default_nettype none

module tic_select (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  tic_pkg::val_t               values [tic_pkg::LANES],
    input  tic_pkg::val_t               iso_level,
    output logic                        valid_o,
    output tic_pkg::item_meta_t         meta_o,
    output tic_pkg::val_t               vs_o [tic_pkg::LANES],
    output tic_pkg::val_t               ve_o [tic_pkg::LANES],
    output logic [tic_pkg::LANES-1:0]   above_o
);
    import tic_pkg::*;

    logic [LANES-1:0] up;
    logic [2:0]       case_idx;
    logic             quad;
    vidx_t            slot [LANES];
    item_meta_t       meta_next;
    val_t             vs_next [LANES];
    val_t             ve_next [LANES];
    logic [LANES-1:0] above_next;

    logic             valid_reg;
    item_meta_t       meta_reg;
    val_t             vs_reg [LANES];
    val_t             ve_reg [LANES];
    logic [LANES-1:0] above_reg;

    // Classify vertices, pick the case, apply winding and fetch edge operands
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            up[k] = values[k] > iso_level;
        end
        case_idx          = {up[1] ^ up[0], up[2] ^ up[0], up[3] ^ up[0]};
        quad              = QUAD_CASES[case_idx];
        meta_next.cut     = (case_idx != '0);
        meta_next.is_quad = quad;
        for (int k = 0; k < LANES; k++) begin
            slot[k] = vidx_t'(k);
            // vertex 0 above: reverse the winding
            if (up[0]) begin
                if (quad) begin
                    if (k == 1)      slot[k] = vidx_t'(3);
                    else if (k == 3) slot[k] = vidx_t'(1);
                end else begin
                    if (k == 1)      slot[k] = vidx_t'(2);
                    else if (k == 2) slot[k] = vidx_t'(1);
                end
            end
            meta_next.edges[k] = case_edge(case_idx, slot[k]);
            vs_next[k]         = values[meta_next.edges[k].from_v];
            ve_next[k]         = values[meta_next.edges[k].to_v];
            above_next[k]      = up[meta_next.edges[k].from_v];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta_reg  <= meta_next;
            vs_reg    <= vs_next;
            ve_reg    <= ve_next;
            above_reg <= above_next;
        end
    end

    assign valid_o = valid_reg;
    assign meta_o  = meta_reg;
    assign vs_o    = vs_reg;
    assign ve_o    = ve_reg;
    assign above_o = above_reg;

endmodule

`default_nettype wire

// ===== design/tic_lane.sv =====
`default_nettype none

module tic_lane (
    input  logic           aclk,
    input  logic           adv,
    input  tic_pkg::val_t  iso_level,
    input  tic_pkg::eps_t  clamp_eps,
    input  tic_pkg::val_t  vs,
    input  tic_pkg::val_t  ve,
    input  logic           src_above,
    output tic_pkg::frac_t fraction
);
    import tic_pkg::*;

    typedef logic [VAL_W-1:0] mag_t;

    mag_t  nm_next, dm_next;
    mag_t  nm_reg, dm_reg;
    mag_t  rem_reg [QBITS-1];
    mag_t  dm_pipe_reg [QBITS-1];
    logic  small_pipe_reg [QBITS];
    frac_t quo_reg [QBITS];
    frac_t f_raw;
    logic [FRAC_W:0] f_plus;
    frac_t frac_next, frac_reg;

    // Ends lie on opposite sides, so both distances are non-negative and fit 32 bits
    always_comb begin
        if (src_above) begin
            nm_next = mag_t'(vs - iso_level);
            dm_next = mag_t'(vs - ve);
        end else begin
            nm_next = mag_t'(iso_level - vs);
            dm_next = mag_t'(ve - vs);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nm_reg <= nm_next;
            dm_reg <= dm_next;
        end
    end

    // Restoring divider, one quotient bit per stage, MSB (the whole part) first
    for (genvar j = 0; j < QBITS; j++) begin : g_step
        logic [VAL_W:0]   r_in;
        logic [VAL_W+1:0] diff;
        mag_t             d_in;
        logic             small_in;
        frac_t            q_in;
        logic             geq;

        if (j == 0) begin : g_first
            assign r_in     = {1'b0, nm_reg};
            assign d_in     = dm_reg;
            assign small_in = (dm_reg < mag_t'(clamp_eps));
            assign q_in     = '0;
        end else begin : g_rest
            assign r_in     = {rem_reg[j-1], 1'b0};
            assign d_in     = dm_pipe_reg[j-1];
            assign small_in = small_pipe_reg[j-1];
            assign q_in     = quo_reg[j-1];
        end

        assign diff = {1'b0, r_in} - {2'b00, d_in};
        assign geq  = !diff[VAL_W+1];

        always_ff @(posedge aclk) begin
            if (adv) begin
                small_pipe_reg[j] <= small_in;
                quo_reg[j]        <= {q_in[FRAC_W-2:0], geq};
            end
        end

        // remainder and divisor are not needed past the last step
        if (j < QBITS - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[j]     <= geq ? diff[VAL_W-1:0] : r_in[VAL_W-1:0];
                    dm_pipe_reg[j] <= d_in;
                end
            end
        end
    end

    // Degenerate edge and end clamps
    assign f_raw  = quo_reg[QBITS-1];
    assign f_plus = {1'b0, f_raw} + (FRAC_W + 1)'(clamp_eps);

    always_comb begin
        if (small_pipe_reg[QBITS-1] || (f_raw < frac_t'(clamp_eps))) begin
            frac_next = '0;
        end else if (f_plus > {1'b0, FRAC_ONE}) begin
            frac_next = FRAC_ONE;
        end else begin
            frac_next = f_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            frac_reg <= frac_next;
        end
    end

    assign fraction = frac_reg;

endmodule

`default_nettype wire

// ===== design/tic_merge.sv =====
`default_nettype none

module tic_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  tic_pkg::item_meta_t meta,
    input  tic_pkg::frac_t      fracs [tic_pkg::LANES],
    output logic                load_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output tic_pkg::vidx_t      m_from_vertex,
    output tic_pkg::vidx_t      m_to_vertex,
    output tic_pkg::frac_t      m_fraction,
    output tic_pkg::vidx_t      m_corner,
    output logic                m_is_quad,
    output logic                m_last
);
    import tic_pkg::*;

    logic       buf_valid_reg, buf_valid_next;
    vidx_t      corner_reg, corner_next;
    item_meta_t meta_reg;
    frac_t      frac_reg [LANES];
    logic       is_last;
    logic       take;

    assign is_last = (corner_reg == (meta_reg.is_quad ? LAST_QUAD : LAST_TRI));
    assign take    = buf_valid_reg && m_ready;
    // a new polygon may enter as the final corner of the held one leaves
    assign load_ok = !buf_valid_reg || (m_ready && is_last);

    always_comb begin
        buf_valid_next = buf_valid_reg;
        corner_next    = corner_reg;
        if (take) begin
            if (is_last) buf_valid_next = 1'b0;
            else         corner_next    = corner_reg + vidx_t'(1);
        end
        if (load) begin
            buf_valid_next = 1'b1;
            corner_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            corner_reg    <= '0;
        end else begin
            buf_valid_reg <= buf_valid_next;
            corner_reg    <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            meta_reg <= meta;
            frac_reg <= fracs;
        end
    end

    // Corner select from the held polygon
    assign m_valid       = buf_valid_reg;
    assign m_from_vertex = meta_reg.edges[corner_reg].from_v;
    assign m_to_vertex   = meta_reg.edges[corner_reg].to_v;
    assign m_fraction    = frac_reg[corner_reg];
    assign m_corner      = corner_reg;
    assign m_is_quad     = meta_reg.is_quad;
    assign m_last        = is_last;

endmodule

`default_nettype wire

// ===== design/tetra_isosurface_cut.sv =====
// Channel   Direction  Handshake           Contents
// s_        in         s_valid / s_ready   four vertex scalars of one tetrahedron
// m_        out        m_valid / m_ready   one polygon corner per request
// APB       in/out     psel, penable       iso_level at 0x0, clamp_eps at 0x4
//
// An accepted tetrahedron passes the select register, lane registers and the merge
// buffer before its first corner is on m_. The single result channel sets the rate;
// all four lane dividers run in step, and an uncut tetrahedron leaves without it.
// Reset is synchronous on aresetn low; there is no clearing pass. Back-pressure on m_
// freezes the whole lane pipeline once a cut item waits at its tail; s_ready drops.
`default_nettype none

module tetra_isosurface_cut (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tic_pkg::val_t                 s_value_0,
    input  tic_pkg::val_t                 s_value_1,
    input  tic_pkg::val_t                 s_value_2,
    input  tic_pkg::val_t                 s_value_3,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tic_pkg::vidx_t                m_from_vertex,
    output tic_pkg::vidx_t                m_to_vertex,
    output tic_pkg::frac_t                m_fraction,
    output tic_pkg::vidx_t                m_corner,
    output logic                          m_is_quad,
    output logic                          m_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tic_pkg::ADDR_W-1:0]    paddr,
    input  logic [tic_pkg::DATA_W-1:0]    pwdata,
    output logic [tic_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import tic_pkg::*;

    val_t             iso_level_reg;
    eps_t             clamp_eps_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    val_t             in_values [LANES];
    logic             sel_valid;
    item_meta_t       sel_meta;
    val_t             sel_vs [LANES];
    val_t             sel_ve [LANES];
    logic [LANES-1:0] sel_above;

    frac_t            lane_frac [LANES];

    logic             valid_pipe_reg [LANE_DEPTH];
    item_meta_t       meta_pipe_reg [LANE_DEPTH];

    logic             adv;
    logic             tail_valid;
    item_meta_t       tail_meta;
    logic             tail_take;
    logic             merge_ok;
    logic             merge_load;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iso_level_reg <= ISO_RESET;
            clamp_eps_reg <= EPS_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ISO_LEVEL: iso_level_reg <= val_t'(pwdata);
                REG_CLAMP_EPS: clamp_eps_reg <= pwdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ISO_LEVEL: prdata = DATA_W'(iso_level_reg);
            REG_CLAMP_EPS: prdata = DATA_W'(clamp_eps_reg);
            default:       prdata = '0;
        endcase
    end

    // Pipeline advance: the tail either leaves (uncut) or enters the merge buffer
    assign tail_valid = valid_pipe_reg[LANE_DEPTH-1];
    assign tail_meta  = meta_pipe_reg[LANE_DEPTH-1];
    assign tail_take  = tail_valid && (!tail_meta.cut || merge_ok);
    assign merge_load = tail_valid && tail_meta.cut && merge_ok;
    assign adv        = !tail_valid || tail_take;
    assign s_ready    = adv;

    assign in_values[0] = s_value_0;
    assign in_values[1] = s_value_1;
    assign in_values[2] = s_value_2;
    assign in_values[3] = s_value_3;

    tic_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .values    (in_values),
        .iso_level (iso_level_reg),
        .valid_o   (sel_valid),
        .meta_o    (sel_meta),
        .vs_o      (sel_vs),
        .ve_o      (sel_ve),
        .above_o   (sel_above)
    );

    // One fraction lane per corner slot
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        tic_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .iso_level (iso_level_reg),
            .clamp_eps (clamp_eps_reg),
            .vs        (sel_vs[k]),
            .ve        (sel_ve[k]),
            .src_above (sel_above[k]),
            .fraction  (lane_frac[k])
        );
    end

    // Item valid and edge info, kept in step with the lane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANE_DEPTH; i++) begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            valid_pipe_reg[0] <= sel_valid;
            for (int i = 1; i < LANE_DEPTH; i++) begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta_pipe_reg[0] <= sel_meta;
            for (int i = 1; i < LANE_DEPTH; i++) begin
                meta_pipe_reg[i] <= meta_pipe_reg[i-1];
            end
        end
    end

    tic_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (merge_load),
        .meta          (tail_meta),
        .fracs         (lane_frac),
        .load_ok       (merge_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_from_vertex (m_from_vertex),
        .m_to_vertex   (m_to_vertex),
        .m_fraction    (m_fraction),
        .m_corner      (m_corner),
        .m_is_quad     (m_is_quad),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// ===== design/tic_checker.sv =====
`default_nettype none

`include "tetra_isosurface_cut_assert.svh"

module tic_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_from_vertex,
    input  logic [1:0]  m_to_vertex,
    input  logic [16:0] m_fraction,
    input  logic [1:0]  m_corner,
    input  logic        m_is_quad,
    input  logic        m_last
);

    // The final corner is number 2 of a triangle, number 3 of a quad
    `TIC_ASSERT_NOW(a_last_corner, m_valid && m_last, m_corner == (m_is_quad ? 2'd3 : 2'd2), "last flag on wrong corner")

    // A cut edge joins two different vertices
    `TIC_ASSERT_NOW(a_edge_ends, m_valid, m_from_vertex != m_to_vertex, "cut edge with equal ends")

    // Fraction never exceeds one
    `TIC_ASSERT_NOW(a_frac_range, m_valid, !m_fraction[16] || (m_fraction[15:0] == 16'h0000), "fraction above one")

    // Corners of one polygon follow without a gap, in order
    `TIC_ASSERT_NEXT(a_corner_step, m_valid && m_ready && !m_last, m_valid && (m_corner == $past(m_corner) + 2'd1) && (m_is_quad == $past(m_is_quad)), "corner sequence broken")

    // A stalled corner holds
    `TIC_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_corner) && $stable(m_fraction), "stalled corner changed")

endmodule

bind tetra_isosurface_cut tic_checker u_tic_checker (.*);

`default_nettype wire
